// ===== sv/qnr_pkg.sv =====
// Shared types, constants and helpers for the quadric normal / reflection pipeline.
// No dependencies; imported by qnr_norm, the top level and the testbench.
`default_nettype none

package qnr_pkg;

  localparam int CW         = 21;            // bits per vector component
  localparam int DFRAC      = CW - 2;        // direction fraction bits
  localparam int PFRAC      = CW - 11;       // position fraction bits
  localparam int VEC_W      = 3 * CW;
  localparam int MAG_W      = 30;            // normalized magnitude width
  localparam int LEN_W      = MAG_W + 1;     // sqrt result width
  localparam int Q_W        = DFRAC + 1;     // quotient width
  localparam int SQRT_STEPS = 32;
  localparam int REM_W      = MAG_W + DFRAC + 2;
  localparam logic [63:0] PLANE_EPS = (64'd1 << (2 * DFRAC)) / 64'd100000;

  typedef enum logic [1:0] {
    SHAPE_SPHERE   = 2'd0,
    SHAPE_PLANE    = 2'd1,
    SHAPE_CYLINDER = 2'd2,
    SHAPE_CONE     = 2'd3
  } shape_e;

  typedef logic [2:0][63:0] wide3_t;

  typedef struct packed {
    logic [VEC_W-1:0] vec_a;
    logic [VEC_W-1:0] vec_b;
    logic             flag_a;
  } side_t;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
    side_t      side;
  } ctl_t;

  typedef struct packed {
    logic [1:0]       shape_kind;
    logic [VEC_W-1:0] hit_point;
    logic [VEC_W-1:0] ray_origin;
    logic [VEC_W-1:0] ray_dir;
    logic [31:0]      hit_distance;
    logic [VEC_W-1:0] obj_position;
    logic [VEC_W-1:0] obj_axis;
    logic [23:0]      cone_slope_sq;
    logic [VEC_W-1:0] view_dir;
  } in_t;

  typedef struct packed {
    logic [VEC_W-1:0] surface_normal;
    logic [VEC_W-1:0] reflected_dir;
    logic             degenerate;
  } out_t;

  function automatic logic signed [CW-1:0] comp(logic [VEC_W-1:0] v, int i);
    return v[i*CW +: CW];
  endfunction

endpackage

`default_nettype wire

// ===== sv/qnr_norm.sv =====
// Pipelined 3-vector normalizer: magnitude scaling, digit-by-digit sqrt, restoring divide.
// Depends on qnr_pkg. Carries a side_t payload alongside each item.
`default_nettype none

module qnr_norm
  import qnr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  wide3_t           vec_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [VEC_W-1:0] vec_o,
  output logic             zero_o,
  output side_t            side_o
);

  localparam int GRP       = 8;
  localparam int DIV_STEPS = Q_W;
  localparam int LEAD_POS  = MAG_W - 1;
  localparam int SQ_W      = 2 * MAG_W;

  // stage 1: magnitudes and signs
  ctl_t   c1_d, c1_q;
  wide3_t mag1_d, mag1_q;

  always_comb begin
    c1_d       = '0;
    c1_d.valid = valid_i;
    c1_d.side  = side_i;
    for (int i = 0; i < 3; i++) begin
      mag1_d[i]   = vec_i[i][63] ? (64'd0 - vec_i[i]) : vec_i[i];
      c1_d.neg[i] = vec_i[i][63];
    end
  end

  // stage 2: per-byte leading one
  ctl_t                  c2_q;
  wide3_t                mag2_q;
  logic [GRP-1:0]        gany2_d, gany2_q;
  logic [GRP-1:0][2:0]   gpos2_d, gpos2_q;
  logic [63:0]           orv;

  always_comb begin
    orv = mag1_q[0] | mag1_q[1] | mag1_q[2];
    for (int g = 0; g < GRP; g++) begin
      gany2_d[g] = |orv[g*8 +: 8];
      gpos2_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orv[g*8+b]) gpos2_d[g] = 3'(b);
      end
    end
  end

  // stage 3: leading one of the largest magnitude
  ctl_t       c3_d, c3_q;
  wide3_t     mag3_q;
  logic [5:0] lead3_d, lead3_q;

  always_comb begin
    c3_d      = c2_q;
    c3_d.zero = ~|gany2_q;
    lead3_d   = '0;
    for (int g = 0; g < GRP; g++) begin
      if (gany2_q[g]) lead3_d = {3'(g), gpos2_q[g]};
    end
  end

  // stage 4: scale so the largest lies in [2^29, 2^30)
  ctl_t                  c4_q;
  logic [2:0][MAG_W-1:0] mag4_d, mag4_q;
  logic [63:0]           sh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead3_q >= 6'(LEAD_POS)) sh = mag3_q[i] >> (lead3_q - 6'(LEAD_POS));
      else                         sh = mag3_q[i] << (6'(LEAD_POS) - lead3_q);
      mag4_d[i] = sh[MAG_W-1:0];
    end
  end

  // stage 5: squares
  ctl_t                  c5_q;
  logic [2:0][MAG_W-1:0] mag5_q;
  logic [2:0][SQ_W-1:0]  sq5_d, sq5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) sq5_d[i] = mag4_q[i] * mag4_q[i];
  end

  // sqrt pipeline, index 0 is the sum-of-squares register
  logic [63:0]           sx_q [SQRT_STEPS+1];
  logic [63:0]           sr_q [SQRT_STEPS+1];
  logic [2:0][MAG_W-1:0] sm_q [SQRT_STEPS+1];
  ctl_t                  sc_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q     <= '0;
      c2_q     <= '0;
      c3_q     <= '0;
      c4_q     <= '0;
      c5_q     <= '0;
      sc_q[0]  <= '0;
    end else if (adv_i) begin
      c1_q     <= c1_d;
      c2_q     <= c1_q;
      c3_q     <= c3_d;
      c4_q     <= c3_q;
      c5_q     <= c4_q;
      sc_q[0]  <= c5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag1_q  <= mag1_d;
      mag2_q  <= mag1_q;
      gany2_q <= gany2_d;
      gpos2_q <= gpos2_d;
      mag3_q  <= mag2_q;
      lead3_q <= lead3_d;
      mag4_q  <= mag4_d;
      mag5_q  <= mag4_q;
      sq5_q   <= sq5_d;
      sx_q[0] <= 64'(sq5_q[0]) + 64'(sq5_q[1]) + 64'(sq5_q[2]);
      sr_q[0] <= '0;
      sm_q[0] <= mag5_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int J = SQRT_STEPS - 1 - k;
    logic [63:0] bit_v, trial, x_d, r_d;

    always_comb begin
      bit_v = 64'd1 << (2 * J);
      trial = sr_q[k] + bit_v;
      if (sx_q[k] >= trial) begin
        x_d = sx_q[k] - trial;
        r_d = (sr_q[k] >> 1) + bit_v;
      end else begin
        x_d = sx_q[k];
        r_d = sr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sc_q[k+1] <= '0;
      end else if (adv_i) begin
        sc_q[k+1] <= sc_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sx_q[k+1] <= x_d;
        sr_q[k+1] <= r_d;
        sm_q[k+1] <= sm_q[k];
      end
    end
  end

  // restoring divide: q = mag * 2^DFRAC / len, one quotient bit per stage
  logic [2:0][REM_W-1:0] dr_q [DIV_STEPS+1];
  logic [2:0][Q_W-1:0]   dq_q [DIV_STEPS+1];
  logic [LEN_W-1:0]      dl_q [DIV_STEPS+1];
  ctl_t                  dc_q [DIV_STEPS+1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr_q[0][i] = {{(REM_W-MAG_W-DFRAC){1'b0}}, sm_q[SQRT_STEPS][i], {DFRAC{1'b0}}};
    end
    dq_q[0] = '0;
    dl_q[0] = sr_q[SQRT_STEPS][LEN_W-1:0];
    dc_q[0] = sc_q[SQRT_STEPS];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int J = DIV_STEPS - 1 - k;
    logic [REM_W-1:0]      dv;
    logic [2:0][REM_W-1:0] r_d;
    logic [2:0][Q_W-1:0]   q_d;

    always_comb begin
      dv = REM_W'(dl_q[k]) << J;
      for (int i = 0; i < 3; i++) begin
        if (dr_q[k][i] >= dv) begin
          r_d[i] = dr_q[k][i] - dv;
          q_d[i] = dq_q[k][i] | (Q_W'(1) << J);
        end else begin
          r_d[i] = dr_q[k][i];
          q_d[i] = dq_q[k][i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dc_q[k+1] <= '0;
      end else if (adv_i) begin
        dc_q[k+1] <= dc_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dr_q[k+1] <= r_d;
        dq_q[k+1] <= q_d;
        dl_q[k+1] <= dl_q[k];
      end
    end
  end

  // output stage: apply signs, force zero for a zero-length input
  ctl_t             co_q;
  logic [VEC_W-1:0] vec_d, vec_q;
  logic [CW-1:0]    cv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cv = CW'(dq_q[DIV_STEPS][i]);
      if (dc_q[DIV_STEPS].neg[i]) cv = CW'(0) - cv;
      if (dc_q[DIV_STEPS].zero)   cv = '0;
      vec_d[i*CW +: CW] = cv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_q <= '0;
    end else if (adv_i) begin
      co_q <= dc_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) vec_q <= vec_d;
  end

  assign valid_o = co_q.valid;
  assign vec_o   = vec_q;
  assign zero_o  = co_q.zero;
  assign side_o  = co_q.side;

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_o |-> vec_o == '0)
    else $error("zero-length item gave a nonzero vector");

  a_nonzero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !zero_o |-> vec_o != '0)
    else $error("nonzero item normalized to zero");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q[SQRT_STEPS].valid && !sc_q[SQRT_STEPS].zero |->
      sr_q[SQRT_STEPS][63:MAG_W-1] != '0 && sr_q[SQRT_STEPS][63:LEN_W] == '0)
    else $error("sqrt length outside the scaled range");

endmodule

`default_nettype wire

// ===== sv/quadric_normal_and_reflection_top.sv =====
// Surface normal and normalized reflection for one quadric ray hit, fully pipelined.
// Depends on qnr_pkg and qnr_norm (two instances: normal, then reflection).
//
//   channel | valid       | stall       | payload
//   input   | in_valid_i  | in_stall_o  | in_item_i  (in_t)
//   output  | out_valid_o | out_stall_i | out_item_o (out_t)
//
// One item per cycle while no result waits under stall; the pipeline is made of the two normalizers (32 sqrt steps
// and 20 divide steps each) plus the dot, projection and reflection stages.
// The whole pipeline, bubbles included, holds while a result waits under stall.
// Reset clears the valid bits and the normalizers' control registers; data registers are not reset.
`default_nettype none

module quadric_normal_and_reflection_top
  import qnr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_item_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_item_o
);

  localparam int HD_W  = CW + 1;
  localparam int PDA_W = 2 * CW;
  localparam int POA_W = 2 * CW + 1;
  localparam int DDA_W = PDA_W + 2;
  localparam int DOA_W = POA_W + 2;
  localparam int DS_W  = DDA_W - DFRAC;
  localparam int MQ_W  = DS_W + 33;
  localparam int OS    = PFRAC + DFRAC - 16;
  localparam int DOS_W = DOA_W - OS;
  localparam int K_W   = 25;
  localparam int A0_W  = 33 + CW;
  localparam int A1F_W = 32 + CW;
  localparam int TN_W  = DS_W + CW;

  typedef struct packed {
    shape_e                kind;
    logic [2:0][HD_W-1:0]  hd;
    logic [VEC_W-1:0]      ax;
    logic [VEC_W-1:0]      vd;
    logic [31:0]           t;
    logic [23:0]           k;
    logic                  is_plane;
    logic [VEC_W-1:0]      nplane;
  } car_t;

  logic adv, acc;
  logic out_valid_q;
  out_t out_item_q;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;
  assign acc        = in_valid_i && adv;

  logic [11:1] vld_q;

  // S1
  in_t it1_q;

  // S2: differences
  car_t                 car2_d, car2_q;
  logic [2:0][HD_W-1:0] od2_d, od2_q;
  logic [VEC_W-1:0]     rd2_q;

  always_comb begin
    logic signed [CW-1:0]   hp, ro, pos;
    logic signed [HD_W-1:0] dh, dro;
    car2_d      = '0;
    car2_d.kind = shape_e'(it1_q.shape_kind);
    car2_d.ax   = it1_q.obj_axis;
    car2_d.vd   = it1_q.view_dir;
    car2_d.t    = it1_q.hit_distance;
    car2_d.k    = it1_q.cone_slope_sq;
    for (int i = 0; i < 3; i++) begin
      hp  = comp(it1_q.hit_point, i);
      ro  = comp(it1_q.ray_origin, i);
      pos = comp(it1_q.obj_position, i);
      dh  = hp - pos;
      dro = ro - pos;
      car2_d.hd[i] = dh;
      od2_d[i]     = dro;
    end
  end

  // S3: products for the two axis dots
  car_t                    car3_q;
  logic signed [PDA_W-1:0] pda3_d [3];
  logic signed [PDA_W-1:0] pda3_q [3];
  logic signed [POA_W-1:0] poa3_d [3];
  logic signed [POA_W-1:0] poa3_q [3];

  always_comb begin
    logic signed [CW-1:0] rdi, axi;
    for (int i = 0; i < 3; i++) begin
      rdi       = comp(rd2_q, i);
      axi       = comp(car2_q.ax, i);
      pda3_d[i] = rdi * axi;
      poa3_d[i] = $signed(od2_q[i]) * axi;
    end
  end

  // S4: dot sums
  car_t                    car4_q;
  logic signed [DDA_W-1:0] dda4_d, dda4_q;
  logic signed [DOA_W-1:0] doa4_d, doa4_q;

  always_comb begin
    dda4_d = pda3_q[0] + pda3_q[1] + pda3_q[2];
    doa4_d = poa3_q[0] + poa3_q[1] + poa3_q[2];
  end

  // S5: plane normal, dot(d,a)*t
  car_t                    car5_d, car5_q;
  logic signed [MQ_W-1:0]  mq5_d, mq5_q;
  logic signed [DOS_W-1:0] doa5_d, doa5_q;

  always_comb begin
    logic signed [DS_W-1:0] ds;
    logic signed [32:0]     ts;
    logic signed [CW-1:0]   a, c;
    logic                   neg;
    car5_d          = car4_q;
    car5_d.is_plane = (car4_q.kind == SHAPE_PLANE);
    neg             = dda4_q > $signed({1'b0, PLANE_EPS[DDA_W-2:0]});
    for (int i = 0; i < 3; i++) begin
      a = comp(car4_q.ax, i);
      c = a;
      if (neg) begin
        // negating the most negative value saturates
        if (a == {1'b1, {(CW-1){1'b0}}}) c = {1'b0, {(CW-1){1'b1}}};
        else                             c = -a;
      end
      car5_d.nplane[i*CW +: CW] = c;
    end
    ds     = DS_W'(dda4_q >>> DFRAC);
    ts     = $signed({1'b0, car4_q.t});
    mq5_d  = ds * ts;
    doa5_d = DOS_W'(doa4_q >>> OS);
  end

  // S6: projection m, 16 fraction bits
  car_t               car6_q;
  logic signed [63:0] m6_d, m6_q;

  always_comb begin
    m6_d = (mq5_q >>> DFRAC) + doa5_q;
  end

  // S7: cone scale as two partial products
  car_t                 car7_q;
  logic signed [63:0]   m7_q;
  logic [K_W-1:0]       kk;
  logic [K_W+31:0]      p0_d, p0_q;
  logic signed [K_W+32:0] p1_d, p1_q;

  always_comb begin
    kk   = K_W'(65536) + K_W'(car6_q.k);
    p0_d = m6_q[31:0] * kk;
    p1_d = $signed(m6_q[63:32]) * $signed({1'b0, kk});
  end

  // S8: cone select, position-scaled mp
  car_t               car8_q;
  logic signed [63:0] mp8_d, mp8_q;

  always_comb begin
    logic [63:0]        mc;
    logic signed [63:0] mm;
    mc = 64'(p0_q) + {p1_q[31:0], 32'd0};
    if (car7_q.kind == SHAPE_CONE) mm = $signed(mc) >>> 16;
    else                           mm = m7_q;
    mp8_d = mm >>> (16 - PFRAC);
  end

  // S9: mp * axis, low 64 bits as two partial products
  car_t                   car9_q;
  logic signed [A0_W-1:0] a0_d [3];
  logic signed [A0_W-1:0] a0_q [3];
  logic [31:0]            a1_d [3];
  logic [31:0]            a1_q [3];

  always_comb begin
    logic signed [CW-1:0]    axs;
    logic signed [A1F_W-1:0] a1f;
    for (int i = 0; i < 3; i++) begin
      axs     = comp(car8_q.ax, i);
      a0_d[i] = $signed({1'b0, mp8_q[31:0]}) * axs;
      a1f     = $signed(mp8_q[63:32]) * axs;
      a1_d[i] = a1f[31:0];
    end
  end

  // S10: combine partials
  car_t               car10_q;
  logic signed [63:0] pr10_d [3];
  logic signed [63:0] pr10_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr10_d[i] = {{(64-A0_W){a0_q[i][A0_W-1]}}, a0_q[i]} + {a1_q[i], 32'd0};
    end
  end

  // S11: vector to normalize
  wide3_t w11_d, w11_q;
  side_t  side11_d, side11_q;

  always_comb begin
    logic signed [HD_W-1:0] hds;
    logic signed [63:0]     w;
    for (int i = 0; i < 3; i++) begin
      hds = $signed(car10_q.hd[i]);
      if (car10_q.kind == SHAPE_SPHERE) w = hds;
      else                              w = hds - (pr10_q[i] >>> DFRAC);
      w11_d[i] = w;
    end
    side11_d = '{vec_a: car10_q.vd, vec_b: car10_q.nplane, flag_a: car10_q.is_plane};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[10:1], acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it1_q    <= in_item_i;
      car2_q   <= car2_d;
      od2_q    <= od2_d;
      rd2_q    <= it1_q.ray_dir;
      car3_q   <= car2_q;
      pda3_q   <= pda3_d;
      poa3_q   <= poa3_d;
      car4_q   <= car3_q;
      dda4_q   <= dda4_d;
      doa4_q   <= doa4_d;
      car5_q   <= car5_d;
      mq5_q    <= mq5_d;
      doa5_q   <= doa5_d;
      car6_q   <= car5_q;
      m6_q     <= m6_d;
      car7_q   <= car6_q;
      m7_q     <= m6_q;
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      car8_q   <= car7_q;
      mp8_q    <= mp8_d;
      car9_q   <= car8_q;
      a0_q     <= a0_d;
      a1_q     <= a1_d;
      car10_q  <= car9_q;
      pr10_q   <= pr10_d;
      w11_q    <= w11_d;
      side11_q <= side11_d;
    end
  end

  // surface normal
  logic             n1_valid, n1_zero;
  logic [VEC_W-1:0] n1_vec;
  side_t            n1_side;

  qnr_norm u_norm_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vld_q[11]),
    .vec_i   (w11_q),
    .side_i  (side11_q),
    .valid_o (n1_valid),
    .vec_o   (n1_vec),
    .zero_o  (n1_zero),
    .side_o  (n1_side)
  );

  // reflection stages
  logic [5:1] rv_q;

  logic [VEC_W-1:0] rn1_d, rn1_q, rvd1_q;
  logic             rdeg1_d, rdeg1_q;

  always_comb begin
    rn1_d   = n1_side.flag_a ? n1_side.vec_b : n1_vec;
    rdeg1_d = !n1_side.flag_a && n1_zero;
  end

  logic [VEC_W-1:0]        rn2_q, rvd2_q;
  logic                    rdeg2_q;
  logic signed [PDA_W-1:0] pv2_d [3];
  logic signed [PDA_W-1:0] pv2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) pv2_d[i] = comp(rvd1_q, i) * comp(rn1_q, i);
  end

  logic [VEC_W-1:0]       rn3_q, rvd3_q;
  logic                   rdeg3_q;
  logic signed [DS_W-1:0] dv3_d, dv3_q;

  always_comb begin
    logic signed [DDA_W-1:0] s;
    s     = pv2_q[0] + pv2_q[1] + pv2_q[2];
    dv3_d = DS_W'(s >>> DFRAC);
  end

  logic [VEC_W-1:0]       rn4_q, rvd4_q;
  logic                   rdeg4_q;
  logic signed [TN_W-1:0] tn4_d [3];
  logic signed [TN_W-1:0] tn4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) tn4_d[i] = dv3_q * comp(rn3_q, i);
  end

  wide3_t r5_d, r5_q;
  side_t  side5_d, side5_q;

  always_comb begin
    logic signed [63:0] vx, tx, r;
    for (int i = 0; i < 3; i++) begin
      vx      = comp(rvd4_q, i);
      tx      = tn4_q[i];
      r       = (vx <<< DFRAC) - (tx <<< 1);
      r5_d[i] = r;
    end
    side5_d = '{vec_a: rn4_q, vec_b: '0, flag_a: rdeg4_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= '0;
    end else if (adv) begin
      rv_q <= {rv_q[4:1], n1_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rn1_q   <= rn1_d;
      rvd1_q  <= n1_side.vec_a;
      rdeg1_q <= rdeg1_d;
      rn2_q   <= rn1_q;
      rvd2_q  <= rvd1_q;
      rdeg2_q <= rdeg1_q;
      pv2_q   <= pv2_d;
      rn3_q   <= rn2_q;
      rvd3_q  <= rvd2_q;
      rdeg3_q <= rdeg2_q;
      dv3_q   <= dv3_d;
      rn4_q   <= rn3_q;
      rvd4_q  <= rvd3_q;
      rdeg4_q <= rdeg3_q;
      tn4_q   <= tn4_d;
      r5_q    <= r5_d;
      side5_q <= side5_d;
    end
  end

  // reflected direction
  logic             n2_valid, n2_zero;
  logic [VEC_W-1:0] n2_vec;
  side_t            n2_side;

  qnr_norm u_norm_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (rv_q[5]),
    .vec_i   (r5_q),
    .side_i  (side5_q),
    .valid_o (n2_valid),
    .vec_o   (n2_vec),
    .zero_o  (n2_zero),
    .side_o  (n2_side)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= n2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_q.surface_normal <= n2_side.vec_a;
      out_item_q.reflected_dir  <= n2_vec;
      out_item_q.degenerate     <= n2_side.flag_a || n2_zero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_refl_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.reflected_dir == '0 |-> out_item_o.degenerate)
    else $error("zero reflection without degenerate flag");

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[1])
    else $error("accepted item did not enter the pipeline");

endmodule

`default_nettype wire

// ===== sim/quadric_normal_and_reflection_top_test.sv =====
// Testbench for quadric_normal_and_reflection_top: directed and random ray hits,
// checked against an in-bench fixed-point model of normal and reflection.
// Depends on qnr_pkg and the RTL of the top level only.
`default_nettype none

module quadric_normal_and_reflection_top_test;
  import qnr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CMAX_C = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN_C = -CMAX_C - 1;
  localparam int N_RANDOM = 1000;
  localparam int CALM_TAIL = 150;
  localparam int TAIL_WAIT = 300;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_item_o;

  quadric_normal_and_reflection_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  in_t    hit_q[$];
  bit     drain_q[$];     // item waits until every expected result has come
  out_t   shade_q[$];     // expected results, oldest first
  int     errors = 0;
  longint cycles = 0;
  logic   in_taken = 1'b0;
  int     send_gap = 0;
  int     stall_left = 0;

  // ---------------- fixed-point model ----------------
  function automatic longint comp_of(logic [VEC_W-1:0] v, int i);
    logic signed [CW-1:0] c;
    c = v[i*CW +: CW];
    return longint'(c);
  endfunction

  function automatic logic [VEC_W-1:0] pack_sat(longint v[3]);
    logic [VEC_W-1:0] r;
    longint c;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      c = v[i];
      if (c > CMAX_C) c = CMAX_C;
      if (c < CMIN_C) c = CMIN_C;
      r[i*CW +: CW] = c[CW-1:0];
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // returns 1 on zero length
  function automatic bit unit_vec(input longint c[3], output longint o[3]);
    longint unsigned mag[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] << DFRAC) / len;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic out_t shade_hit(in_t h);
    longint hp[3], ro[3], rd[3], pos[3], ax[3], vd[3];
    longint n[3], w[3], r[3], rn[3];
    longint t, k, m, mp, dv, drd, dvo;
    bit degn, degr;
    shape_e kind;
    out_t o;
    kind = shape_e'(h.shape_kind);
    t = longint'({32'd0, h.hit_distance});
    k = longint'({40'd0, h.cone_slope_sq});
    degn = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hp[i] = comp_of(h.hit_point, i);
      ro[i] = comp_of(h.ray_origin, i);
      rd[i] = comp_of(h.ray_dir, i);
      pos[i] = comp_of(h.obj_position, i);
      ax[i] = comp_of(h.obj_axis, i);
      vd[i] = comp_of(h.view_dir, i);
    end
    drd = rd[0] * ax[0] + rd[1] * ax[1] + rd[2] * ax[2];
    case (kind)
      SHAPE_SPHERE: begin
        for (int i = 0; i < 3; i++) w[i] = hp[i] - pos[i];
        degn = unit_vec(w, n);
      end
      SHAPE_PLANE: begin
        for (int i = 0; i < 3; i++) begin
          n[i] = (drd > longint'(PLANE_EPS)) ? -ax[i] : ax[i];
          if (n[i] > CMAX_C) n[i] = CMAX_C;
        end
      end
      default: begin
        dvo = 0;
        for (int i = 0; i < 3; i++) dvo += (ro[i] - pos[i]) * ax[i];
        m = ((drd >>> DFRAC) * t) >>> DFRAC;
        m += dvo >>> (PFRAC + DFRAC - 16);
        if (kind == SHAPE_CONE) m = (m * (65536 + k)) >>> 16;
        mp = m >>> (16 - PFRAC);
        for (int i = 0; i < 3; i++) w[i] = (hp[i] - pos[i]) - ((mp * ax[i]) >>> DFRAC);
        degn = unit_vec(w, n);
      end
    endcase
    dv = (vd[0] * n[0] + vd[1] * n[1] + vd[2] * n[2]) >>> DFRAC;
    for (int i = 0; i < 3; i++) r[i] = (vd[i] <<< DFRAC) - 2 * dv * n[i];
    degr = unit_vec(r, rn);
    o.surface_normal = pack_sat(n);
    o.reflected_dir = pack_sat(rn);
    o.degenerate = degn | degr;
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic [VEC_W-1:0] vec3(longint x, longint y, longint z);
    logic [VEC_W-1:0] v;
    v = {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
    return v;
  endfunction

  function automatic logic [VEC_W-1:0] wild_vec();
    return VEC_W'({$urandom, $urandom});
  endfunction

  // components of moderate size, so the geometry stays meaningful
  function automatic logic [VEC_W-1:0] tame_vec(int span);
    longint c[3];
    for (int i = 0; i < 3; i++) c[i] = longint'($urandom_range(0, 2 * span)) - span;
    return vec3(c[0], c[1], c[2]);
  endfunction

  function automatic in_t random_hit();
    in_t h;
    h.shape_kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      h.hit_point = wild_vec();
      h.ray_origin = wild_vec();
      h.ray_dir = wild_vec();
      h.obj_position = wild_vec();
      h.obj_axis = wild_vec();
      h.view_dir = wild_vec();
      h.hit_distance = $urandom;
      h.cone_slope_sq = 24'($urandom);
    end else begin
      h.hit_point = tame_vec(20000);
      h.ray_origin = tame_vec(20000);
      h.ray_dir = tame_vec(1 << 19);
      h.obj_position = tame_vec(20000);
      h.obj_axis = tame_vec(1 << 19);
      h.view_dir = tame_vec(1 << 19);
      h.hit_distance = $urandom_range(0, 32'h00FF_FFFF);
      h.cone_slope_sq = 24'($urandom_range(0, 1 << 17));
    end
    return h;
  endfunction

  task automatic queue_hit(in_t h, bit drain);
    hit_q.push_back(h);
    drain_q.push_back(drain);
  endtask

  task automatic report(string what, logic [VEC_W-1:0] got, logic [VEC_W-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---------------- clock, reset, stimulus ----------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_t h;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;

    // directed part
    h = '0;
    for (int s = 0; s < 4; s++) begin
      h.shape_kind = 2'(s);       // all-zero hit: zero normals, zero view
      queue_hit(h, 1'b0);
    end
    h = '1;
    for (int s = 0; s < 4; s++) begin
      h.shape_kind = 2'(s);
      queue_hit(h, 1'b0);
    end
    h = '0;
    h.shape_kind = SHAPE_SPHERE;
    h.hit_point = vec3(3000, -2000, 500);
    h.obj_position = vec3(1000, 0, 0);
    h.view_dir = vec3(0, 0, -(1 << 19));
    queue_hit(h, 1'b0);
    h.view_dir = '0;                // zero reflection
    queue_hit(h, 1'b0);
    h = '0;
    h.shape_kind = SHAPE_PLANE;
    h.obj_axis = vec3(0, 1 << 19, 0);
    h.ray_dir = vec3(0, 1 << 18, 0);   // facing along axis: negate
    h.view_dir = vec3(1 << 18, -(1 << 18), 0);
    queue_hit(h, 1'b0);
    h.ray_dir = vec3(0, -(1 << 18), 0);
    queue_hit(h, 1'b0);
    h.ray_dir = vec3(0, 1, 0);         // tiny dot stays under threshold
    queue_hit(h, 1'b0);
    h.obj_axis = vec3(CMIN_C, CMIN_C, CMIN_C);
    h.ray_dir = vec3(CMIN_C, 0, 0);    // negation of most negative saturates
    queue_hit(h, 1'b0);
    h.obj_axis = '0;                   // zero plane axis, not flagged
    queue_hit(h, 1'b0);
    h = '0;
    h.shape_kind = SHAPE_CYLINDER;
    h.hit_point = vec3(2048, 4096, 1024);
    h.ray_origin = vec3(0, -8192, 0);
    h.ray_dir = vec3(0, 1 << 19, 0);
    h.obj_axis = vec3(0, 1 << 19, 0);
    h.hit_distance = 32'h0004_0000;
    h.view_dir = vec3(1 << 19, 0, 0);
    queue_hit(h, 1'b0);
    h.shape_kind = SHAPE_CONE;
    queue_hit(h, 1'b0);
    h.cone_slope_sq = '1;
    h.hit_distance = '1;
    queue_hit(h, 1'b0);
    h.shape_kind = SHAPE_CYLINDER;     // hit on the axis: zero normal
    h.hit_point = '0;
    h.ray_origin = '0;
    h.obj_axis = '0;
    queue_hit(h, 1'b0);
    h.hit_point = vec3(CMAX_C, CMIN_C, CMAX_C);
    h.obj_position = vec3(CMIN_C, CMAX_C, CMIN_C);
    h.view_dir = vec3(CMIN_C, CMIN_C, CMAX_C);
    h.obj_axis = vec3(CMAX_C, CMIN_C, CMAX_C);
    h.ray_dir = vec3(CMIN_C, CMIN_C, CMIN_C);
    h.ray_origin = vec3(CMAX_C, CMAX_C, CMIN_C);
    h.shape_kind = SHAPE_CONE;
    queue_hit(h, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) queue_hit(random_hit(), i == N_RANDOM / 2);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (hit_q.size() == 0);
    @(posedge clk_i);
    while (in_valid_i) @(posedge clk_i);
    while (shade_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (errors == 0 && shade_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------- driver ----------------
  always @(negedge clk_i) begin
    logic nv;
    in_t  ni;
    bit   calm;
    nv = in_valid_i;
    ni = in_item_i;
    calm = hit_q.size() < CALM_TAIL;
    if (rst_ni) begin
      if (in_valid_i && in_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (hit_q.size() > 0 && !(drain_q[0] && shade_q.size() != 0)) begin
          ni = hit_q.pop_front();
          void'(drain_q.pop_front());
          nv = 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
        end
      end
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
      end
      in_valid_i <= nv;
      in_item_i <= ni;
    end
  end

  // ---------------- acceptance, prediction and checking ----------------
  always @(posedge clk_i) begin
    out_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_taken <= rst_ni && in_valid_i && !in_stall_o;
      if (rst_ni && in_valid_i && !in_stall_o) shade_q.push_back(shade_hit(in_item_i));
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (shade_q.size() == 0) begin
          report("unexpected item", out_item_o.surface_normal, '0);
        end else begin
          want = shade_q.pop_front();
          if (out_item_o.surface_normal !== want.surface_normal)
            report("surface_normal", out_item_o.surface_normal, want.surface_normal);
          if (out_item_o.reflected_dir !== want.reflected_dir)
            report("reflected_dir", out_item_o.reflected_dir, want.reflected_dir);
          if (out_item_o.degenerate !== want.degenerate)
            report("degenerate", VEC_W'(out_item_o.degenerate), VEC_W'(want.degenerate));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/qnr_pkg.sv
sv/qnr_norm.sv
sv/quadric_normal_and_reflection_top.sv
sim/quadric_normal_and_reflection_top_test.sv
